@@ src/rgbhsv_pkg.sv @@
// rgbhsv_pkg: shared types and constants for the RGB to HSV pixel converter.
// No dependencies; imported by every module of the block.
package rgbhsv_pkg;

	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned CELL_COUNT = CHAN_W;
	localparam int unsigned HUE_REM_W  = 17;
	localparam int unsigned HUE_DIV_W  = CHAN_W + 1;
	localparam int unsigned SAT_REM_W  = 2 * CHAN_W;
	localparam logic [CHAN_W-1:0] HUE_HALF_MAX = 8'd179;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_rgb_t;

	typedef struct packed {
		logic [CHAN_W-1:0] hue_half;
		logic [CHAN_W-1:0] saturation;
		logic [CHAN_W-1:0] brightness;
	} pixel_hsv_t;

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	// Data handed from cell to cell along the divider chain.
	typedef struct packed {
		logic                 valid;
		logic                 flat;
		logic [CHAN_W-1:0]    brightness;
		logic [HUE_REM_W-1:0] hue_rem;
		logic [HUE_DIV_W-1:0] hue_div;
		logic [CHAN_W-1:0]    hue_q;
		logic [SAT_REM_W-1:0] sat_rem;
		logic [CHAN_W-1:0]    sat_div;
		logic [CHAN_W-1:0]    sat_q;
	} cell_data_t;

endpackage

@@ src/rgbhsv_prep.sv @@
// rgbhsv_prep: two pipeline stages that find max, min and sector, then form the
// hue and saturation dividends and divisors. Depends on rgbhsv_pkg.
module rgbhsv_prep (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    valid,
	input  rgbhsv_pkg::pixel_rgb_t  pixel,
	output rgbhsv_pkg::cell_data_t  data
);
	import rgbhsv_pkg::*;

	logic              valid_s1;
	logic [CHAN_W-1:0] hi_s1;
	logic [CHAN_W-1:0] d_s1;
	logic signed [CHAN_W:0] diff_s1;
	sector_t           sector_s1;

	logic [CHAN_W-1:0] hi_c;
	logic [CHAN_W-1:0] lo_c;
	logic signed [CHAN_W:0] diff_c;
	sector_t           sector_c;

	logic signed [18:0] diff_x;
	logic signed [18:0] d_x;
	logic signed [18:0] offs;
	logic signed [18:0] num_raw;
	logic signed [18:0] num_wrap;
	cell_data_t         data_c;
	cell_data_t         data_s2;

	always_comb begin
		if (pixel.red >= pixel.green && pixel.red >= pixel.blue) begin
			hi_c     = pixel.red;
			sector_c = SEC_RED;
			diff_c   = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
		end else if (pixel.green >= pixel.blue) begin
			hi_c     = pixel.green;
			sector_c = SEC_GREEN;
			diff_c   = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
		end else begin
			hi_c     = pixel.blue;
			sector_c = SEC_BLUE;
			diff_c   = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
		end
		lo_c = pixel.red;
		if (pixel.green < lo_c) lo_c = pixel.green;
		if (pixel.blue < lo_c) lo_c = pixel.blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			hi_s1     <= '0;
			d_s1      <= '0;
			diff_s1   <= '0;
			sector_s1 <= SEC_RED;
		end else if (en) begin
			valid_s1  <= valid;
			hi_s1     <= hi_c;
			d_s1      <= hi_c - lo_c;
			diff_s1   <= diff_c;
			sector_s1 <= sector_c;
		end
	end

	always_comb begin
		diff_x = 19'(diff_s1);
		d_x    = $signed({11'b0, d_s1});
		unique case (sector_s1)
			SEC_RED:   offs = 19'sd0;
			SEC_GREEN: offs = 19'sd120;
			SEC_BLUE:  offs = 19'sd240;
			default:   offs = 19'sd0;
		endcase
		num_raw  = diff_x * 19'sd60 + d_x * offs;
		num_wrap = num_raw[18] ? num_raw + d_x * 19'sd360 : num_raw;

		data_c.valid      = valid_s1;
		data_c.flat       = (d_s1 == '0);
		data_c.brightness = hi_s1;
		data_c.hue_rem    = num_wrap[HUE_REM_W-1:0];
		data_c.hue_div    = {d_s1, 1'b0};
		data_c.hue_q      = '0;
		data_c.sat_rem    = {d_s1, 8'b0} - {8'b0, d_s1};
		data_c.sat_div    = hi_s1;
		data_c.sat_q      = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_s2 <= '0;
		end else if (en) begin
			data_s2 <= data_c;
		end
	end

	assign data = data_s2;

endmodule

@@ src/rgbhsv_div_cell.sv @@
// rgbhsv_div_cell: one restoring-division step for the hue and saturation lanes,
// one quotient bit each, registered. Depends on rgbhsv_pkg.
module rgbhsv_div_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  rgbhsv_pkg::cell_data_t  prev,
	output rgbhsv_pkg::cell_data_t  next
);
	import rgbhsv_pkg::*;

	logic [HUE_REM_W-1:0] hue_cmp;
	logic                 hue_ge;
	logic [HUE_REM_W-1:0] hue_sel;
	logic [SAT_REM_W-1:0] sat_cmp;
	logic                 sat_ge;
	logic [SAT_REM_W-1:0] sat_sel;
	cell_data_t           step_c;
	cell_data_t           data_q;

	always_comb begin
		hue_cmp = {1'b0, prev.hue_div, 7'b0};
		hue_ge  = prev.hue_rem >= hue_cmp;
		hue_sel = hue_ge ? prev.hue_rem - hue_cmp : prev.hue_rem;
		sat_cmp = {1'b0, prev.sat_div, 7'b0};
		sat_ge  = prev.sat_rem >= sat_cmp;
		sat_sel = sat_ge ? prev.sat_rem - sat_cmp : prev.sat_rem;

		step_c         = prev;
		step_c.hue_rem = {hue_sel[HUE_REM_W-2:0], 1'b0};
		step_c.hue_q   = {prev.hue_q[CHAN_W-2:0], hue_ge};
		step_c.sat_rem = {sat_sel[SAT_REM_W-2:0], 1'b0};
		step_c.sat_q   = {prev.sat_q[CHAN_W-2:0], sat_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (en) begin
			data_q <= step_c;
		end
	end

	assign next = data_q;

endmodule

@@ src/rgbhsv_skid.sv @@
// rgbhsv_skid: output register with one spare entry so that the pipeline's
// advance depends only on registered state. Depends on rgbhsv_pkg.
module rgbhsv_skid (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  rgbhsv_pkg::pixel_hsv_t  push_data,
	output logic                    room,
	output logic                    hsv_valid,
	input  logic                    hsv_ready,
	output rgbhsv_pkg::pixel_hsv_t  hsv
);
	import rgbhsv_pkg::*;

	logic       out_valid_q;
	pixel_hsv_t out_q;
	logic       spare_valid_q;
	pixel_hsv_t spare_q;
	logic       take;

	assign take = out_valid_q && hsv_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else begin
			priority if (!out_valid_q || take) begin
				if (spare_valid_q) begin
					out_valid_q   <= 1'b1;
					spare_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else begin
				spare_valid_q <= spare_valid_q || push;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			out_q <= spare_valid_q ? spare_q : push_data;
		end
		if (push && out_valid_q && !take) begin
			spare_q <= push_data;
		end
	end

	assign room      = !spare_valid_q;
	assign hsv_valid = out_valid_q;
	assign hsv       = out_q;

endmodule

@@ src/rgb_to_hsv_pixel.sv @@
// rgb_to_hsv_pixel: top level of the 8-bit RGB to HSV converter (hue halved).
// Depends on rgbhsv_pkg, rgbhsv_prep, rgbhsv_div_cell and rgbhsv_skid.
//
// Takes one pixel per clock and returns one HSV pixel per clock, in order, while
// the consumer keeps up. Acceptance to hsv_valid passes two front stages (max/min
// and sector selection, then the hue and saturation dividends), a chain of
// eight division cells that each settle one quotient bit of both hue and
// saturation, and an output register. A spare entry behind the output register
// keeps rgb_ready registered; once a stall fills the spare entry, the whole chain holds.
module rgb_to_hsv_pixel (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rgb_valid,
	output logic                    rgb_ready,
	input  rgbhsv_pkg::pixel_rgb_t  rgb,
	output logic                    hsv_valid,
	input  logic                    hsv_ready,
	output rgbhsv_pkg::pixel_hsv_t  hsv
);
	import rgbhsv_pkg::*;

	logic       pipe_en;
	cell_data_t chain [0:CELL_COUNT];
	pixel_hsv_t result;
	logic       push;

	rgbhsv_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (pipe_en),
		.valid  (rgb_valid),
		.pixel  (rgb),
		.data   (chain[0])
	);

	for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
		rgbhsv_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (pipe_en),
			.prev   (chain[i]),
			.next   (chain[i+1])
		);
	end

	always_comb begin
		result.hue_half   = chain[CELL_COUNT].flat ? '0 : chain[CELL_COUNT].hue_q;
		result.saturation = chain[CELL_COUNT].flat ? '0 : chain[CELL_COUNT].sat_q;
		result.brightness = chain[CELL_COUNT].brightness;
	end

	assign push      = pipe_en && chain[CELL_COUNT].valid;
	assign rgb_ready = pipe_en;

	rgbhsv_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (result),
		.room      (pipe_en),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.hsv       (hsv)
	);

endmodule

@@ src/rgbhsv_checker.sv @@
// rgbhsv_checker: port-level assertions for rgb_to_hsv_pixel, bound to the top.
// Depends on rgbhsv_pkg.
module rgbhsv_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    hsv_valid,
	input  logic                    hsv_ready,
	input  rgbhsv_pkg::pixel_hsv_t  hsv
);
	import rgbhsv_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !hsv_ready |=> hsv_valid)
		else $error("hsv transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !hsv_ready |=> $stable(hsv))
		else $error("hsv payload changed while stalled");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hsv.hue_half <= HUE_HALF_MAX)
		else $error("hue_half out of range");

	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv.saturation == '0 |-> hsv.hue_half == '0)
		else $error("hue nonzero on grey pixel");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv.brightness == '0 |-> hsv.saturation == '0)
		else $error("saturation nonzero on black pixel");

endmodule

bind rgb_to_hsv_pixel rgbhsv_checker u_rgbhsv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.hsv_valid (hsv_valid),
	.hsv_ready (hsv_ready),
	.hsv       (hsv)
);
